@@ rtl/core/ckl_pkg.sv @@
`timescale 1ns / 1ps

package ckl_pkg;

    localparam int KEY_W   = 32;
    localparam int BAL_W   = 32;
    localparam int POS_W   = 7;
    localparam int CNT_W   = 8;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } status_t;

    // one stored record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [BAL_W-1:0] bal;
    } entry_t;

    typedef struct packed {
        status_t          status;
        logic [POS_W-1:0] position;
        logic [BAL_W-1:0] found_balance;
        logic [CNT_W-1:0] entry_count;
    } result_t;

endpackage

@@ rtl/core/ckl_if.sv @@
`timescale 1ns / 1ps

interface ckl_req_if;
    logic                             valid;
    logic                             ready;
    logic [ckl_pkg::CMD_W-1:0]        cmd;
    logic signed [ckl_pkg::KEY_W-1:0] account;
    logic [ckl_pkg::BAL_W-1:0]        balance;

    modport source (output valid, cmd, account, balance, input ready);
    modport sink   (input valid, cmd, account, balance, output ready);
endinterface

interface ckl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ckl_pkg::STAT_W-1:0] status;
    logic [ckl_pkg::POS_W-1:0]  position;
    logic [ckl_pkg::BAL_W-1:0]  found_balance;
    logic [ckl_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, status, position, found_balance, entry_count, input ready);
    modport sink   (input valid, status, position, found_balance, entry_count, output ready);
endinterface

@@ rtl/core/compacting_keyed_list.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                          Accepted when
// req      in   cmd, account, balance                            req.valid && req.ready
// resp     out  status, position, found_balance, entry_count     resp.valid && resp.ready
//
// Insert and clear go from idle straight to the done state. Search and delete walk the table
// when it is not empty, through the single read port of the record memory, reading and
// comparing each entry visited; delete then moves each later entry down one place.
// The done state loads the output register; req.ready is high while the sequencer idles,
// even if a result still waits in that register. A stalled resp holds the sequencer
// in its done state. Reset clears the count; the record memory is never cleared.

module compacting_keyed_list #(
    parameter int CAPACITY = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    ckl_req_if.sink    req,
    ckl_rsp_if.source  resp
);
    import ckl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic       seq_idle;
    logic       seq_done;
    logic       take;
    result_t    seq_result;
    logic       mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    entry_t     mem_wdata;
    entry_t     mem_rdata;

    logic       valid_reg;
    result_t    result_reg;

    assign req.ready = seq_idle;
    assign take      = seq_done && (!valid_reg || resp.ready);

    ckl_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && seq_idle),
        .cmd       (cmd_t'(req.cmd)),
        .key       (req.account),
        .bal       (req.balance),
        .idle      (seq_idle),
        .done      (seq_done),
        .take      (take),
        .result    (seq_result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    ckl_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (resp.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= seq_result;
        end
    end

    assign resp.valid         = valid_reg;
    assign resp.status        = result_reg.status;
    assign resp.position      = result_reg.position;
    assign resp.found_balance = result_reg.found_balance;
    assign resp.entry_count   = result_reg.entry_count;

endmodule

@@ rtl/core/ckl_store.sv @@
`timescale 1ns / 1ps

module ckl_store #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ckl_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output ckl_pkg::entry_t rdata
);
    import ckl_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ckl_seq.sv @@
`timescale 1ns / 1ps

module ckl_seq #(
    parameter int CAPACITY = 128,
    parameter int AW       = 7,
    parameter int CW       = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ckl_pkg::cmd_t               cmd,
    input  logic [ckl_pkg::KEY_W-1:0]   key,
    input  logic [ckl_pkg::BAL_W-1:0]   bal,
    output logic                        idle,
    output logic                        done,
    input  logic                        take,
    output ckl_pkg::result_t            result,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output ckl_pkg::entry_t             mem_wdata,
    output logic [AW-1:0]               mem_raddr,
    input  ckl_pkg::entry_t             mem_rdata
);
    import ckl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    cmd_t               cmd_reg, cmd_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    status_t            status_reg, status_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BAL_W-1:0]   fbal_reg, fbal_next;

    logic [CW-1:0]      idx_ext;
    logic [CW-1:0]      idx_inc;
    logic               key_hit;

    assign idx_ext = CW'(idx_reg);
    assign idx_inc = idx_ext + CW'(1);
    // the shared comparator: stored key against the requested key
    assign key_hit = (mem_rdata.key == key_reg);

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        fbal_next   = fbal_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = mem_rdata;
        mem_raddr   = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    key_next    = key;
                    idx_next    = '0;
                    status_next = ST_OK;
                    pos_next    = '0;
                    fbal_next   = '0;
                    state_next  = S_DONE;
                    case (cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = count_reg[AW-1:0];
                                mem_wdata.key  = key;
                                mem_wdata.bal  = bal;
                                pos_next       = POS_W'(count_reg);
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_MISSING;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (key_hit)
                begin
                    pos_next = POS_W'(idx_reg);
                    if (cmd_reg == CMD_SEARCH)
                    begin
                        fbal_next  = mem_rdata.bal;
                        state_next = S_DONE;
                    end
                    else if (idx_inc < count_reg)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_DONE;
                    end
                end
                else if (idx_inc < count_reg)
                begin
                    idx_next   = idx_inc[AW-1:0];
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
            end
            S_SHIFT_RD:
            begin
                mem_raddr  = idx_inc[AW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // move entry idx+1 down into idx
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = idx_inc[AW-1:0];
                if ((idx_ext + CW'(2)) < count_reg)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            count_reg  <= '0;
            cmd_reg    <= CMD_INSERT;
            key_reg    <= '0;
            status_reg <= ST_OK;
            pos_reg    <= '0;
            fbal_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            cmd_reg    <= cmd_next;
            key_reg    <= key_next;
            status_reg <= status_next;
            pos_reg    <= pos_next;
            fbal_reg   <= fbal_next;
        end
    end

    assign idle                 = (state_reg == S_IDLE);
    assign done                 = (state_reg == S_DONE);
    assign result.status        = status_reg;
    assign result.position      = pos_reg;
    assign result.found_balance = fbal_reg;
    assign result.entry_count   = CNT_W'(count_reg);

endmodule

@@ dv/compacting_keyed_list_test.sv @@
`timescale 1ns / 1ps

module compacting_keyed_list_test;
    import ckl_pkg::*;

    localparam int TABLE_DEPTH = 128;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;

    logic clk;
    logic rst_n;

    ckl_req_if req_if ();
    ckl_rsp_if resp_if ();

    compacting_keyed_list #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .resp (resp_if)
    );

    // shadow copy of the account table
    logic [KEY_W-1:0] ledger_keys [TABLE_DEPTH];
    logic [BAL_W-1:0] ledger_bals [TABLE_DEPTH];
    int unsigned      ledger_count;

    result_t          pending_results [$];
    logic [KEY_W-1:0] key_pool [16];
    int unsigned      error_count;
    bit               send_idle_en;
    bit               resp_stall_en;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Applies one request to the shadow table and returns the response it should give.
    function automatic result_t apply_request(cmd_t op, logic [KEY_W-1:0] key,
                                              logic [BAL_W-1:0] bal);
        result_t     res;
        int unsigned hit;
        bit          found;
        res.status = ST_OK;
        res.position = '0;
        res.found_balance = '0;
        found = 1'b0;
        hit = 0;
        if (op == CMD_SEARCH || op == CMD_DELETE)
        begin
            for (int unsigned i = 0; i < ledger_count; i++)
            begin
                if (!found && ledger_keys[i] == key)
                begin
                    found = 1'b1;
                    hit = i;
                end
            end
        end
        case (op)
            CMD_INSERT:
            begin
                if (ledger_count >= TABLE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    ledger_keys[ledger_count] = key;
                    ledger_bals[ledger_count] = bal;
                    res.position = POS_W'(ledger_count);
                    ledger_count++;
                end
            end
            CMD_SEARCH:
            begin
                if (!found)
                    res.status = ST_MISSING;
                else
                begin
                    res.position = POS_W'(hit);
                    res.found_balance = ledger_bals[hit];
                end
            end
            CMD_DELETE:
            begin
                if (!found)
                    res.status = ST_MISSING;
                else
                begin
                    res.position = POS_W'(hit);
                    for (int unsigned i = hit; i + 1 < ledger_count; i++)
                    begin
                        ledger_keys[i] = ledger_keys[i + 1];
                        ledger_bals[i] = ledger_bals[i + 1];
                    end
                    ledger_count--;
                end
            end
            default:
                ledger_count = 0;
        endcase
        res.entry_count = CNT_W'(ledger_count);
        return res;
    endfunction

    task automatic send_request(cmd_t op, logic [KEY_W-1:0] key, logic [BAL_W-1:0] bal);
        while (send_idle_en && $urandom_range(99) < 8)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
        end
        @(negedge clk);
        req_if.valid <= 1'b1;
        req_if.cmd <= op;
        req_if.account <= key;
        req_if.balance <= bal;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        pending_results.push_back(apply_request(op, key, bal));
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // response stalls
    always @(negedge clk)
    begin
        if (rst_n)
            resp_if.ready <= !(resp_stall_en && $urandom_range(99) < 8);
    end

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && resp_if.valid === 1'b1 && resp_if.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: response with no request pending: status %0d pos %0d",
                             resp_if.status, resp_if.position);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (resp_if.status !== exp_res.status
                    || resp_if.position !== exp_res.position
                    || resp_if.found_balance !== exp_res.found_balance
                    || resp_if.entry_count !== exp_res.entry_count)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"ERROR: expected status %0d pos %0d bal %h count %0d,",
                                  " got status %0d pos %0d bal %h count %0d"},
                                 exp_res.status, exp_res.position, exp_res.found_balance,
                                 exp_res.entry_count, resp_if.status, resp_if.position,
                                 resp_if.found_balance, resp_if.entry_count);
                end
            end
        end
    end

    task automatic test_basic_commands();
        // empty table: misses and a clear with nothing in it
        send_request(CMD_SEARCH, 32'h1234_5678, $urandom);
        send_request(CMD_DELETE, 32'h1234_5678, $urandom);
        send_request(CMD_CLEAR, $urandom, $urandom);
        send_request(CMD_INSERT, 32'h8000_0000, 32'h0000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
        // duplicate key: first one wins
        send_request(CMD_SEARCH, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_SEARCH, 32'h8000_0000, $urandom);
        send_request(CMD_SEARCH, 32'hFFFF_FFFF, $urandom);
        send_request(CMD_SEARCH, 32'h1234_5678, $urandom);
        send_request(CMD_DELETE, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_SEARCH, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_DELETE, 32'hFFFF_FFFF, $urandom);
        send_request(CMD_DELETE, 32'h7FFF_FFFF, $urandom);
        send_request(CMD_SEARCH, 32'h0000_0000, $urandom);
        send_request(CMD_DELETE, 32'h8000_0000, $urandom);
        send_request(CMD_CLEAR, $urandom, $urandom);
        send_request(CMD_SEARCH, 32'h0000_0000, $urandom);
        send_request(CMD_INSERT, 32'h0000_0000, 32'hDEAD_BEEF);
        send_request(CMD_SEARCH, 32'h0000_0000, $urandom);
    endtask

    task automatic test_full_table();
        send_request(CMD_CLEAR, $urandom, $urandom);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(CMD_INSERT, $urandom, $urandom);
        send_request(CMD_INSERT, $urandom, $urandom);
        send_request(CMD_INSERT, ledger_keys[0], $urandom);
        send_request(CMD_SEARCH, ledger_keys[TABLE_DEPTH - 1], $urandom);
        send_request(CMD_DELETE, ledger_keys[0], $urandom);
        send_request(CMD_INSERT, $urandom, $urandom);
        send_request(CMD_DELETE, ledger_keys[TABLE_DEPTH - 1], $urandom);
        send_request(CMD_SEARCH, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(int n_items);
        cmd_t             op;
        logic [KEY_W-1:0] key;
        int unsigned      roll;
        bit               growing;
        for (int k = 0; k < n_items; k++)
        begin
            if (k == 350)
                send_idle_en = 1'b0;
            if (k == 350)
                resp_stall_en = 1'b0;
            if (k == 550)
            begin
                send_idle_en = 1'b1;
                resp_stall_en = 1'b1;
            end
            if (k == 700)
                wait_for_results();
            // alternate between filling the table toward full and draining it
            growing = (k % 500) < 300;
            roll = $urandom_range(999);
            if (roll < 5)
                op = CMD_CLEAR;
            else if (growing)
                op = roll < 650 ? CMD_INSERT : (roll < 880 ? CMD_SEARCH : CMD_DELETE);
            else
                op = roll < 150 ? CMD_INSERT : (roll < 400 ? CMD_SEARCH : CMD_DELETE);
            if (op == CMD_INSERT)
                key = $urandom_range(1) ? key_pool[$urandom_range(15)] : $urandom;
            else if (ledger_count > 0 && $urandom_range(99) < 75)
                key = ledger_keys[$urandom_range(ledger_count - 1)];
            else
                key = $urandom_range(1) ? key_pool[$urandom_range(15)] : $urandom;
            send_request(op, key, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.cmd = CMD_INSERT;
        req_if.account = '0;
        req_if.balance = '0;
        resp_if.ready = 1'b1;
        ledger_count = 0;
        error_count = 0;
        send_idle_en = 1'b1;
        resp_stall_en = 1'b1;
        for (int i = 0; i < 16; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_basic_commands();
        test_full_table();
        test_random_traffic(1200);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ckl_pkg.sv
rtl/core/ckl_if.sv
rtl/core/ckl_store.sv
rtl/core/ckl_seq.sv
rtl/core/compacting_keyed_list.sv
dv/compacting_keyed_list_test.sv
